FILE: rtl/ptw_pkg.sv
package ptw_pkg;

  localparam int VaWidth    = 48;
  localparam int EntryWidth = 64;
  localparam int PaWidth    = 52;
  localparam int IdxWidth   = 9;

  typedef enum logic [1:0] {
    ST_READ     = 2'd0,
    ST_DONE     = 2'd1,
    ST_UNMAPPED = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_RESPONSE  = 1'b1
  } cmd_t;

  // Tables still to read after the awaited entry: 3 means the level-4 entry.
  localparam logic [1:0] LevelTop  = 2'd3;
  localparam logic [1:0] LevelHuge = 2'd1;
  localparam logic [1:0] LevelLeaf = 2'd0;

  localparam int PresentBit = 0;
  localparam int HugeBit    = 7;

  typedef struct packed {
    logic               busy;
    logic [1:0]         level;
    logic [VaWidth-1:0] saved_va;
  } walk_state_t;

  typedef struct packed {
    status_t            status;
    logic [PaWidth-1:0] read_addr;
    logic [PaWidth-1:0] phys_addr;
  } walk_result_t;

  function automatic logic [IdxWidth-1:0] table_index(input logic [VaWidth-1:0] va,
                                                      input logic [1:0] lvl);
    logic [IdxWidth-1:0] idx;
    case (lvl)
      2'd3:    idx = va[47:39];
      2'd2:    idx = va[38:30];
      2'd1:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

FILE: rtl/ptw_cfg.sv
module ptw_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output logic [ptw_pkg::PaWidth-1:0] root_table_base
);
  import ptw_pkg::*;

  logic sel_root;

  // Register i sits at byte address 8*i; only index 0 exists.
  assign sel_root = (paddr[3] == 1'b0);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_base <= '0;
    end else if (psel && penable && pwrite && pready && sel_root) begin
      root_table_base <= pwdata[PaWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_root) begin
      prdata = {{(64-PaWidth){1'b0}}, root_table_base};
    end
  end

endmodule

FILE: rtl/ptw_step.sv
module ptw_step (
  input  logic                           cmd,
  input  logic [ptw_pkg::VaWidth-1:0]    virt_addr,
  input  logic [ptw_pkg::EntryWidth-1:0] table_entry,
  input  logic [ptw_pkg::PaWidth-1:0]    root_table_base,
  input  ptw_pkg::walk_state_t           cur,
  output ptw_pkg::walk_state_t           nxt,
  output ptw_pkg::walk_result_t          res
);
  import ptw_pkg::*;

  logic [39:0] frame;
  logic [1:0]  level_dec;

  assign frame     = table_entry[51:12];
  assign level_dec = cur.level - 2'd1;

  always_comb begin
    nxt           = cur;
    res.status    = ST_BAD;
    res.read_addr = '0;
    res.phys_addr = '0;
    if (cmd == CMD_TRANSLATE) begin
      if (!cur.busy) begin
        nxt.busy      = 1'b1;
        nxt.level     = LevelTop;
        nxt.saved_va  = virt_addr;
        res.status    = ST_READ;
        res.read_addr = {root_table_base[51:12], table_index(virt_addr, LevelTop), 3'b000};
      end
    end else if (cur.busy) begin
      if (!table_entry[PresentBit]) begin
        res.status = ST_UNMAPPED;
        nxt.busy   = 1'b0;
        nxt.level  = LevelLeaf;
      end else if (cur.level == LevelHuge && table_entry[HugeBit]) begin
        // 2 MiB page: frame comes from entry bits 51..21.
        res.status    = ST_DONE;
        res.phys_addr = {table_entry[51:21], cur.saved_va[20:0]};
        nxt.busy      = 1'b0;
        nxt.level     = LevelLeaf;
      end else if (cur.level == LevelLeaf) begin
        res.status    = ST_DONE;
        res.phys_addr = {frame, cur.saved_va[11:0]};
        nxt.busy      = 1'b0;
      end else begin
        res.status    = ST_READ;
        res.read_addr = {frame, table_index(cur.saved_va, level_dec), 3'b000};
        nxt.level     = level_dec;
      end
    end
  end

endmodule

FILE: rtl/four_level_page_table_walker.sv
// Four-level page table walker for 48-bit virtual addresses.
// Input stream (s_*): s_tuser is the command (0 = translate, 1 = memory read
// response); s_tdata carries the virtual address and the 64-bit table entry.
// Output stream (m_*): one result per input item. m_tuser is the status
// (read request, translated, not mapped, unexpected item); m_tdata carries
// the address of the next entry to read and the translated physical address.
// The user issues a read for each read request and feeds the entry back as a
// response item; a walk takes up to four responses.
// The root table base is written through the APB port at address 0, by the
// user only while no item is in flight; the walker does not enforce this.
// Each item passes an input register and then a result register; result
// valid rises once the item leaves the input register. One item is accepted
// per cycle sustained while m_tready stays high. When the receiver stalls,
// the result register holds; an empty input register still takes an item,
// and s_tready is low while it is full. Synchronous reset empties both
// registers and leaves the walker idle with a zero root base.
module four_level_page_table_walker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // [47:0] virt_addr, [111:48] table_entry
  input  logic         s_tuser,  // [0] cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // [51:0] read_addr, [103:52] phys_addr
  output logic [1:0]   m_tuser,  // [1:0] status
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import ptw_pkg::*;

  logic                  in_valid;
  logic                  in_cmd;
  logic [VaWidth-1:0]    in_va;
  logic [EntryWidth-1:0] in_entry;
  logic                  advance;
  logic [PaWidth-1:0]    root_table_base;
  walk_state_t           walk;
  walk_state_t           walk_next;
  walk_result_t          step_res;
  walk_result_t          result;

  ptw_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .root_table_base (root_table_base)
  );

  ptw_step u_step (
    .cmd             (in_cmd),
    .virt_addr       (in_va),
    .table_entry     (in_entry),
    .root_table_base (root_table_base),
    .cur             (walk),
    .nxt             (walk_next),
    .res             (step_res)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_va    <= s_tdata[47:0];
      in_entry <= s_tdata[111:48];
    end
  end

  // Walk state moves when the item leaves the input register, in item order.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      walk     <= '0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
      walk     <= walk_next;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

  assign m_tuser = result.status;
  assign m_tdata = {result.phys_addr, result.read_addr};

  a_read_keeps_busy: assert property (@(posedge clk) disable iff (rst)
    (advance && step_res.status == ST_READ) |=> walk.busy)
    else $error("read request issued but walker went idle");

  a_end_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (advance && (step_res.status == ST_DONE || step_res.status == ST_UNMAPPED))
      |=> !walk.busy)
    else $error("walk ended but walker still busy");

  a_idle_level_zero: assert property (@(posedge clk) disable iff (rst)
    !walk.busy |-> (walk.level == LevelLeaf))
    else $error("idle walker holds a nonzero level");

  a_phys_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.status != ST_DONE) |-> (result.phys_addr == '0))
    else $error("physical address set without translation");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.status != ST_READ) |-> (result.read_addr == '0))
    else $error("read address set without read request");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("pending input item lost");

endmodule
